/* design/srim_pkg.sv */
// Shared types and constants for the systematic resample index map.
package srim_pkg;

    localparam int WEIGHT_W   = 32;
    localparam int SUM_W      = 38;
    localparam int OFFSET_W   = 32;
    localparam int CFG_W      = 7;
    localparam int SLOT_W     = 6;
    localparam int RSUM_W     = 48;
    localparam int CFG_RESET  = 64;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [SUM_W-1:0]    sum_of_weights;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } srim_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] source;
        logic              last_slot;
    } srim_out_t;

endpackage

/* design/srim_div.sv */
// Restoring divider, one quotient bit per cycle, for the batch mean weight.
module srim_div
    import srim_pkg::*;
#(
    parameter int DIVISOR_W = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [SUM_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;
    logic [SUM_W-1:0]     q_reg, q_next;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb
    begin
        shifted = {rem_reg, q_reg[SUM_W-1]};
        diff    = shifted - {1'b0, div_reg};
        fits    = ~diff[DIVISOR_W];

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            rem_next  = '0;
            div_next  = divisor;
            q_next    = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            q_next    = {q_reg[SUM_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* design/systematic_resample_index_map_core.sv */
// Top level: systematic resampler that turns weights into ancestor indices.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, always ready) sets the particle count,
//   latched at the first word of each batch; 0 acts as 1, values above
//   MAX_PARTICLES act as MAX_PARTICLES. Write it only while the block is idle.
//   in channel (in_valid/in_stall) takes one weight word per particle. The
//   first word of a batch also carries the weight total and the draw offset.
//   in_stall is high while a word is being worked on, and also through the
//   map and out phases. The first word runs the serial divider for the mean
//   weight and then the draw loop; later words go straight to the draw loop.
//   After the final word the count store is walked, a read and a check per
//   particle, and each extra copy is written to the next free slot. Then one
//   out word per slot (out_valid/out_stall), each read from the ancestor
//   store and then loaded; the last slot carries last_slot. A stalled out
//   word holds until taken, and the block takes the next batch while the
//   final out word still waits.
//   Reset: asynchronous, clears all control state, particle count reads 64.
module systematic_resample_index_map_core
    import srim_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  srim_in_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output srim_out_t        out_data
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV      = 3'd1;
    localparam logic [2:0] ST_DRAW     = 3'd2;
    localparam logic [2:0] ST_MAP_RD   = 3'd3;
    localparam logic [2:0] ST_MAP_CHK  = 3'd4;
    localparam logic [2:0] ST_MAP_COPY = 3'd5;
    localparam logic [2:0] ST_OUT_RD   = 3'd6;
    localparam logic [2:0] ST_OUT_LD   = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [CFG_W-1:0]         cfg_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [RSUM_W-1:0] rsum_reg, rsum_next;
    logic [SUM_W-1:0]         mean_reg, mean_next;
    logic [OFFSET_W-1:0]      thr_reg, thr_next;
    logic [CNT_W-1:0]         draws_reg, draws_next;
    logic [CNT_W-1:0]         cur_reg, cur_next;
    logic [IDX_W-1:0]         seen_reg, seen_next;
    logic                     lastf_reg, lastf_next;
    logic [IDX_W-1:0]         last_idx_reg, last_idx_next;
    logic [MAX_PARTICLES-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]         c_reg, c_next;
    logic                     out_valid_reg, out_valid_next;
    srim_out_t                out_reg, out_next;

    logic [CNT_W-1:0] cnt_mem [MAX_PARTICLES];
    logic [IDX_W-1:0] anc_mem [MAX_PARTICLES];
    logic [CNT_W-1:0] cnt_rd_reg;
    logic [IDX_W-1:0] anc_rd_reg;

    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wdata;
    logic             anc_we;
    logic [IDX_W-1:0] anc_waddr;
    logic [IDX_W-1:0] anc_wdata;

    logic             in_fire;
    logic             first_word;
    logic [CNT_W-1:0] eff_n;
    logic [CNT_W-1:0] batch_n;
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_q;
    logic             draw_go;
    logic [CNT_W-1:0] chk_cnt;
    logic             i_at_end;
    logic             j_busy;

    srim_div #(
        .DIVISOR_W(CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_data.sum_of_weights),
        .divisor  (eff_n),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_W'(CFG_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg <= cfg_data;
        end
    end

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign first_word = (seen_reg == '0);

    always_comb
    begin
        if (cfg_reg == '0)
            eff_n = CNT_W'(1);
        else if (cfg_reg > CFG_W'(MAX_PARTICLES))
            eff_n = CNT_W'(MAX_PARTICLES);
        else
            eff_n = cfg_reg[CNT_W-1:0];
    end

    assign batch_n  = first_word ? eff_n : n_reg;
    assign draw_go  = ($signed({{(RSUM_W-OFFSET_W){1'b0}}, thr_reg}) < rsum_reg)
                      && (draws_reg < n_reg);
    assign chk_cnt  = (i_reg <= last_idx_reg) ? cnt_rd_reg : '0;
    assign i_at_end = ((CNT_W'(i_reg) + CNT_W'(1)) == n_reg);
    assign j_busy   = (j_reg < n_reg) && occ_reg[j_reg[IDX_W-1:0]];

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        rsum_next      = rsum_reg;
        mean_next      = mean_reg;
        thr_next       = thr_reg;
        draws_next     = draws_reg;
        cur_next       = cur_reg;
        seen_next      = seen_reg;
        lastf_next     = lastf_reg;
        last_idx_next  = last_idx_reg;
        occ_next       = occ_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        c_next         = c_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        div_start      = 1'b0;
        cnt_we         = 1'b0;
        cnt_wdata      = cur_reg;
        anc_we         = 1'b0;
        anc_waddr      = i_reg;
        anc_wdata      = i_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cur_next   = '0;
                    lastf_next = in_data.last
                                 || ((CNT_W'(seen_reg) + CNT_W'(1)) >= batch_n);
                    if (first_word)
                    begin
                        n_next     = eff_n;
                        thr_next   = in_data.offset;
                        rsum_next  = RSUM_W'(in_data.weight);
                        draws_next = '0;
                        occ_next   = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        rsum_next  = rsum_reg + RSUM_W'(in_data.weight);
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_q;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (draw_go)
                begin
                    cur_next   = cur_reg + CNT_W'(1);
                    draws_next = draws_reg + CNT_W'(1);
                    rsum_next  = rsum_reg
                                 - $signed({{(RSUM_W-SUM_W){1'b0}}, mean_reg});
                end
                else
                begin
                    cnt_we = 1'b1;
                    if (lastf_reg)
                    begin
                        // draws still owed go to the final particle
                        cnt_wdata           = cur_reg + (n_reg - draws_reg);
                        occ_next[seen_reg]  = (cnt_wdata != '0);
                        last_idx_next       = seen_reg;
                        seen_next           = '0;
                        draws_next          = '0;
                        rsum_next           = '0;
                        i_next              = '0;
                        j_next              = '0;
                        state_next          = ST_MAP_RD;
                    end
                    else
                    begin
                        occ_next[seen_reg] = (cur_reg != '0);
                        seen_next          = seen_reg + IDX_W'(1);
                        state_next         = ST_IDLE;
                    end
                end
            end
            ST_MAP_RD:
            begin
                state_next = ST_MAP_CHK;
            end
            ST_MAP_CHK:
            begin
                if (chk_cnt != '0)
                begin
                    anc_we = 1'b1;
                end
                if (chk_cnt > CNT_W'(1))
                begin
                    c_next     = chk_cnt;
                    state_next = ST_MAP_COPY;
                end
                else if (i_at_end)
                begin
                    i_next     = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_MAP_RD;
                end
            end
            ST_MAP_COPY:
            begin
                j_next = j_reg + CNT_W'(1);
                if (!j_busy)
                begin
                    // extra copy lands in the next free slot
                    anc_we    = (j_reg < n_reg);
                    anc_waddr = j_reg[IDX_W-1:0];
                    c_next    = c_reg - CNT_W'(1);
                    if (c_reg == CNT_W'(2))
                    begin
                        if (i_at_end)
                        begin
                            i_next     = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_MAP_RD;
                        end
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    out_next.slot      = SLOT_W'(i_reg);
                    out_next.source    = SLOT_W'(anc_rd_reg);
                    out_next.last_slot = i_at_end;
                    if (i_at_end)
                    begin
                        i_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= CNT_W'(MAX_PARTICLES);
            rsum_reg      <= '0;
            mean_reg      <= '0;
            thr_reg       <= '0;
            draws_reg     <= '0;
            cur_reg       <= '0;
            seen_reg      <= '0;
            lastf_reg     <= 1'b0;
            last_idx_reg  <= '0;
            occ_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            rsum_reg      <= rsum_next;
            mean_reg      <= mean_next;
            thr_reg       <= thr_next;
            draws_reg     <= draws_next;
            cur_reg       <= cur_next;
            seen_reg      <= seen_next;
            lastf_reg     <= lastf_next;
            last_idx_reg  <= last_idx_next;
            occ_reg       <= occ_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // offspring count store
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[seen_reg] <= cnt_wdata;
        end
        if (state_reg == ST_MAP_RD)
        begin
            cnt_rd_reg <= cnt_mem[i_reg];
        end
    end

    // ancestor index store
    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_waddr] <= anc_wdata;
        end
        if (state_reg == ST_OUT_RD)
        begin
            anc_rd_reg <= anc_mem[i_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_draws_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        draws_reg <= n_reg
    ) else $error("draw count exceeds batch size");

    a_cur_within_draws: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> (cur_reg <= draws_reg)
    ) else $error("particle offspring exceeds total draws");

    a_copy_pending: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAP_COPY) |-> (c_reg > CNT_W'(1))
    ) else $error("copy walk entered with no extra copies");

    a_out_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg))
    ) else $error("stalled out word changed");

endmodule
